### rtl/core/tkcs_pkg.sv
// Shared types, widths, codes and reset values for the toroidal kinematics step.
package tkcs_pkg;

   localparam int MAX_BODIES_DEFAULT = 8;

   localparam int POS_W   = 20;
   localparam int VEL_W   = 21;
   localparam int THR_W   = 10;
   localparam int GAIN_W  = 12;
   localparam int TS_W    = 16;
   localparam int DIM_W   = 12;
   localparam int BCNT_W  = 4;
   localparam int TICK_W  = 32;
   localparam int CMD_W   = 2;
   localparam int ENTRY_W = 3;
   localparam int REGI_W  = 3;

   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_BODY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_SHIP = 2'd2;

   localparam logic [REGI_W-1:0] REG_ARENA_WIDTH  = 3'd0;
   localparam logic [REGI_W-1:0] REG_ARENA_HEIGHT = 3'd1;
   localparam logic [REGI_W-1:0] REG_ACCEL_GAIN   = 3'd2;
   localparam logic [REGI_W-1:0] REG_TIME_STEP    = 3'd3;
   localparam logic [REGI_W-1:0] REG_BODY_COUNT   = 3'd4;

   localparam logic [DIM_W-1:0]  ARENA_WIDTH_RST  = 12'd800;
   localparam logic [DIM_W-1:0]  ARENA_HEIGHT_RST = 12'd300;
   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST   = 12'd300;
   localparam logic [TS_W-1:0]   TIME_STEP_RST    = 16'd6554;
   localparam logic [BCNT_W-1:0] BODY_COUNT_RST   = 4'd5;

   typedef struct packed {
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
      logic [POS_W-1:0]        r;
   } body_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIP_MUL,
      ST_SHIP_ADD,
      ST_SHIP_VEL,
      ST_BODY_MUL,
      ST_BODY_ADD,
      ST_BODY_SQ,
      ST_BODY_CMP,
      ST_BODY_SKIP,
      ST_DONE
   } state_type;

endpackage

### rtl/core/toroidal_kinematics_collision_step.sv
// Top level of the toroidal kinematics and circle collision step.
//
// The block keeps one ship and a row of MAX_BODIES body cells on a field that wraps at
// its edges. Every request transaction yields exactly one response transaction. A tick
// (command 0) moves the ship with its old velocity, applies the thrust to its velocity,
// then rotates the body chain once round: each active body (index below body_count)
// leaves the head cell, is moved and tested against the ship, and re-enters at the tail,
// while inactive bodies pass through unchanged. Each active body is handled by the shared axis
// movers (multiply, then add and wrap) and then by the squared-distance multipliers and the
// compare, and an inactive body is only skipped. Load commands and the unused command go
// straight to the response. A new request is taken whenever the control is idle, even
// while the previous response still waits to be taken. Configuration registers must only
// be written while idle.
module toroidal_kinematics_collision_step #(
   parameter int MAX_BODIES = tkcs_pkg::MAX_BODIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: thrust_x[9:0], thrust_y[19:10], entry_index[22:20], load_pos_x[42:23],
   //        load_pos_y[62:43], load_vel_x[83:63], load_vel_y[104:84],
   //        load_radius[124:105], zero fill[127:125]
   input  logic [127:0] req_tdata,
   // tuser: command[1:0]
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: tick_count[31:0], ship_pos_x[51:32], ship_pos_y[71:52]
   output logic [71:0]  rsp_tdata,
   // tuser: hit[0]
   output logic         rsp_tuser,
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int CNT_W0 = $clog2(MAX_BODIES + 1);
   localparam int CW     = (CNT_W0 > 4) ? CNT_W0 : 4;
   localparam logic [CW-1:0] LAST_K = CW'(MAX_BODIES - 1);
   localparam logic [CW-1:0] MAX_K  = CW'(MAX_BODIES);

   // Request fields.
   logic signed [9:0]  thrust_x, thrust_y;
   logic [2:0]         entry_index;
   tkcs_pkg::body_type load_body;
   logic [1:0]         command;

   assign thrust_x      = $signed(req_tdata[9:0]);
   assign thrust_y      = $signed(req_tdata[19:10]);
   assign entry_index   = req_tdata[22:20];
   assign load_body.x   = req_tdata[42:23];
   assign load_body.y   = req_tdata[62:43];
   assign load_body.vx  = $signed(req_tdata[83:63]);
   assign load_body.vy  = $signed(req_tdata[104:84]);
   assign load_body.r   = req_tdata[124:105];
   assign command       = req_tuser;

   // Configuration registers.
   logic [11:0] arena_width_ff, arena_height_ff, accel_gain_ff;
   logic [15:0] time_step_ff;
   logic [3:0]  body_count_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_width_ff  <= tkcs_pkg::ARENA_WIDTH_RST;
         arena_height_ff <= tkcs_pkg::ARENA_HEIGHT_RST;
         accel_gain_ff   <= tkcs_pkg::ACCEL_GAIN_RST;
         time_step_ff    <= tkcs_pkg::TIME_STEP_RST;
         body_count_ff   <= tkcs_pkg::BODY_COUNT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            tkcs_pkg::REG_ARENA_WIDTH:  arena_width_ff  <= csr_pwdata[11:0];
            tkcs_pkg::REG_ARENA_HEIGHT: arena_height_ff <= csr_pwdata[11:0];
            tkcs_pkg::REG_ACCEL_GAIN:   accel_gain_ff   <= csr_pwdata[11:0];
            tkcs_pkg::REG_TIME_STEP:    time_step_ff    <= csr_pwdata[15:0];
            tkcs_pkg::REG_BODY_COUNT:   body_count_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tkcs_pkg::REG_ARENA_WIDTH:  csr_prdata = {20'h0, arena_width_ff};
         tkcs_pkg::REG_ARENA_HEIGHT: csr_prdata = {20'h0, arena_height_ff};
         tkcs_pkg::REG_ACCEL_GAIN:   csr_prdata = {20'h0, accel_gain_ff};
         tkcs_pkg::REG_TIME_STEP:    csr_prdata = {16'h0, time_step_ff};
         tkcs_pkg::REG_BODY_COUNT:   csr_prdata = {28'h0, body_count_ff};
         default:                    csr_prdata = 32'h0;
      endcase
   end

   // Control state.
   tkcs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    cmd_ff;
   logic          hit_ff, hit_in;
   logic signed [9:0] thr_x_ff, thr_y_ff;
   logic [CW-1:0] n_active;
   logic          act_first, act_next;
   logic          req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign n_active   = ({{(CW-4){1'b0}}, body_count_ff} > MAX_K) ? MAX_K
                       : {{(CW-4){1'b0}}, body_count_ff};
   assign act_first  = n_active != '0;
   assign act_next   = (k_ff + CW'(1)) < n_active;

   // Ship state.
   logic [19:0]        ship_x_ff, ship_y_ff, ship_size_ff;
   logic signed [20:0] ship_vx_ff, ship_vy_ff;
   logic [31:0]        counter_ff;

   // Body chain.
   tkcs_pkg::body_type cell_out [MAX_BODIES];
   tkcs_pkg::body_type head, tail_in;
   logic               shift_en;
   logic [19:0]        nbx_ff, nby_ff;

   assign head = cell_out[0];

   always_comb begin
      tail_in = head;
      if (state_ff == tkcs_pkg::ST_BODY_CMP) begin
         tail_in.x = nbx_ff;
         tail_in.y = nby_ff;
      end
   end

   for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
      logic load_en;
      assign load_en = req_accept && (command == tkcs_pkg::CMD_LOAD_BODY)
                       && ({{(CW-3){1'b0}}, entry_index} == CW'(k));
      tkcs_cell u_cell (
         .clock     (clock),
         .load_en   (load_en),
         .load_body (load_body),
         .shift_en  (shift_en),
         .shift_in  ((k == MAX_BODIES - 1) ? tail_in : cell_out[(k + 1) % MAX_BODIES]),
         .body_out  (cell_out[k])
      );
   end

   // Shared axis movers, used by the ship first and then by each body in turn.
   logic               mul_en, sel_ship;
   logic signed [20:0] mv_vx, mv_vy;
   logic [19:0]        mv_px, mv_py, next_x, next_y;

   assign mv_vx = sel_ship ? ship_vx_ff : head.vx;
   assign mv_vy = sel_ship ? ship_vy_ff : head.vy;
   assign mv_px = sel_ship ? ship_x_ff  : head.x;
   assign mv_py = sel_ship ? ship_y_ff  : head.y;

   tkcs_axis_unit u_axis_x (
      .clock       (clock),
      .mul_en      (mul_en),
      .vel         (mv_vx),
      .time_step   (time_step_ff),
      .pos         (mv_px),
      .bound_units (arena_width_ff),
      .next_pos    (next_x)
   );

   tkcs_axis_unit u_axis_y (
      .clock       (clock),
      .mul_en      (mul_en),
      .vel         (mv_vy),
      .time_step   (time_step_ff),
      .pos         (mv_py),
      .bound_units (arena_height_ff),
      .next_pos    (next_y)
   );

   // Thrust path: gain times thrust, then times the time step, then saturating add.
   logic signed [22:0] thr1x_ff, thr1y_ff;
   logic signed [39:0] thr2x_ff, thr2y_ff;
   logic signed [24:0] nvx, nvy;
   logic signed [20:0] satx, saty;

   always_ff @(posedge clock) begin
      if (state_ff == tkcs_pkg::ST_SHIP_MUL) begin
         thr1x_ff <= $signed({1'b0, accel_gain_ff}) * thr_x_ff;
         thr1y_ff <= $signed({1'b0, accel_gain_ff}) * thr_y_ff;
      end
      if (state_ff == tkcs_pkg::ST_SHIP_ADD) begin
         thr2x_ff <= thr1x_ff * $signed({1'b0, time_step_ff});
         thr2y_ff <= thr1y_ff * $signed({1'b0, time_step_ff});
      end
   end

   assign nvx = $signed({{4{ship_vx_ff[20]}}, ship_vx_ff})
                + $signed({thr2x_ff[39], thr2x_ff[39:16]});
   assign nvy = $signed({{4{ship_vy_ff[20]}}, ship_vy_ff})
                + $signed({thr2y_ff[39], thr2y_ff[39:16]});

   always_comb begin
      if (nvx > 25'sd1048575) begin
         satx = 21'sd1048575;
      end else if (nvx < -25'sd1048576) begin
         satx = -21'sd1048576;
      end else begin
         satx = nvx[20:0];
      end
      if (nvy > 25'sd1048575) begin
         saty = 21'sd1048575;
      end else if (nvy < -25'sd1048576) begin
         saty = -21'sd1048576;
      end else begin
         saty = nvy[20:0];
      end
   end

   // Overlap test on the moved body and the moved ship, without wrap.
   logic signed [20:0] dx, dy;
   logic [20:0]        rsum;
   logic signed [41:0] dx2_full, dy2_full;
   logic [40:0]        dx2_ff, dy2_ff;
   logic [41:0]        r2_ff;
   logic [41:0]        d2;
   logic               overlap;

   assign dx       = $signed({1'b0, nbx_ff}) - $signed({1'b0, ship_x_ff});
   assign dy       = $signed({1'b0, nby_ff}) - $signed({1'b0, ship_y_ff});
   assign rsum     = {1'b0, head.r} + {1'b0, ship_size_ff};
   assign dx2_full = dx * dx;
   assign dy2_full = dy * dy;
   assign d2       = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign overlap  = d2 <= r2_ff;

   always_ff @(posedge clock) begin
      if (state_ff == tkcs_pkg::ST_BODY_ADD) begin
         nbx_ff <= next_x;
         nby_ff <= next_y;
      end
      if (state_ff == tkcs_pkg::ST_BODY_SQ) begin
         dx2_ff <= dx2_full[40:0];
         dy2_ff <= dy2_full[40:0];
         r2_ff  <= rsum * rsum;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkcs_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (command == tkcs_pkg::CMD_TICK) ? tkcs_pkg::ST_SHIP_MUL
                                                          : tkcs_pkg::ST_DONE;
            end
         end
         tkcs_pkg::ST_SHIP_MUL: state_in = tkcs_pkg::ST_SHIP_ADD;
         tkcs_pkg::ST_SHIP_ADD: state_in = tkcs_pkg::ST_SHIP_VEL;
         tkcs_pkg::ST_SHIP_VEL: begin
            state_in = act_first ? tkcs_pkg::ST_BODY_MUL : tkcs_pkg::ST_BODY_SKIP;
         end
         tkcs_pkg::ST_BODY_MUL: state_in = tkcs_pkg::ST_BODY_ADD;
         tkcs_pkg::ST_BODY_ADD: state_in = tkcs_pkg::ST_BODY_SQ;
         tkcs_pkg::ST_BODY_SQ:  state_in = tkcs_pkg::ST_BODY_CMP;
         tkcs_pkg::ST_BODY_CMP, tkcs_pkg::ST_BODY_SKIP: begin
            if (k_ff == LAST_K) begin
               state_in = tkcs_pkg::ST_DONE;
            end else begin
               state_in = act_next ? tkcs_pkg::ST_BODY_MUL : tkcs_pkg::ST_BODY_SKIP;
            end
         end
         tkcs_pkg::ST_DONE: begin
            if (!rsp_tvalid || rsp_tready) begin
               state_in = tkcs_pkg::ST_IDLE;
            end
         end
         default: state_in = tkcs_pkg::ST_IDLE;
      endcase
   end

   // Output decode of the state.
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      sel_ship   = 1'b0;
      shift_en   = 1'b0;
      unique case (state_ff)
         tkcs_pkg::ST_IDLE:      req_tready = 1'b1;
         tkcs_pkg::ST_SHIP_MUL: begin
            mul_en   = 1'b1;
            sel_ship = 1'b1;
         end
         tkcs_pkg::ST_SHIP_ADD:  sel_ship = 1'b1;
         tkcs_pkg::ST_BODY_MUL:  mul_en   = 1'b1;
         tkcs_pkg::ST_BODY_CMP, tkcs_pkg::ST_BODY_SKIP: shift_en = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      k_in   = k_ff;
      hit_in = hit_ff;
      if (req_accept) begin
         k_in   = '0;
         hit_in = 1'b0;
      end else if (shift_en) begin
         k_in = (k_ff == LAST_K) ? '0 : k_ff + CW'(1);
         if (state_ff == tkcs_pkg::ST_BODY_CMP && overlap) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkcs_pkg::ST_IDLE;
         k_ff     <= '0;
         hit_ff   <= 1'b0;
         cmd_ff   <= tkcs_pkg::CMD_TICK;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         hit_ff   <= hit_in;
         if (req_accept) begin
            cmd_ff <= command;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         thr_x_ff <= thrust_x;
         thr_y_ff <= thrust_y;
      end
   end

   // Ship registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ship_x_ff    <= '0;
         ship_y_ff    <= '0;
         ship_vx_ff   <= '0;
         ship_vy_ff   <= '0;
         ship_size_ff <= '0;
         counter_ff   <= '0;
      end else if (req_accept && command == tkcs_pkg::CMD_LOAD_SHIP) begin
         ship_x_ff    <= load_body.x;
         ship_y_ff    <= load_body.y;
         ship_vx_ff   <= load_body.vx;
         ship_vy_ff   <= load_body.vy;
         ship_size_ff <= load_body.r;
         counter_ff   <= '0;
      end else if (state_ff == tkcs_pkg::ST_SHIP_ADD) begin
         ship_x_ff <= next_x;
         ship_y_ff <= next_y;
      end else if (state_ff == tkcs_pkg::ST_SHIP_VEL) begin
         ship_vx_ff <= satx;
         ship_vy_ff <= saty;
         if (counter_ff != '1) begin
            counter_ff <= counter_ff + 32'd1;
         end
      end
   end

   // Response register: it holds a finished transaction while the next one is worked on.
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [71:0] rsp_data_ff;
   logic        rsp_load;

   assign rsp_load = (state_ff == tkcs_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= {ship_y_ff, ship_x_ff, counter_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // Checks on the control.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_hit_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkcs_pkg::ST_DONE && hit_ff) |-> (cmd_ff == tkcs_pkg::CMD_TICK))
      else $error("hit flagged for a load transaction");

   a_chain_index: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> (k_ff <= LAST_K))
      else $error("body chain index out of range");

   a_rotation_done: assert property (@(posedge clock) disable iff (reset)
      (shift_en && k_ff == LAST_K) |=> (state_ff == tkcs_pkg::ST_DONE && k_ff == '0))
      else $error("body chain did not finish a full rotation");

endmodule

### rtl/core/tkcs_cell.sv
// One body cell of the rotating chain: holds a body and passes it on when shifted.
module tkcs_cell (
   input  logic               clock,
   input  logic               load_en,
   input  tkcs_pkg::body_type load_body,
   input  logic               shift_en,
   input  tkcs_pkg::body_type shift_in,
   output tkcs_pkg::body_type body_out
);

   tkcs_pkg::body_type body_ff;
   tkcs_pkg::body_type body_in;

   always_comb begin
      body_in = body_ff;
      if (load_en) begin
         body_in = load_body;
      end else if (shift_en) begin
         body_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   assign body_out = body_ff;

endmodule

### rtl/core/tkcs_axis_unit.sv
// One axis mover: registered product of velocity and time step, then add and single wrap.
module tkcs_axis_unit (
   input  logic                                  clock,
   input  logic                                  mul_en,
   input  logic signed [tkcs_pkg::VEL_W-1:0]     vel,
   input  logic        [tkcs_pkg::TS_W-1:0]      time_step,
   input  logic        [tkcs_pkg::POS_W-1:0]     pos,
   input  logic        [tkcs_pkg::DIM_W-1:0]     bound_units,
   output logic        [tkcs_pkg::POS_W-1:0]     next_pos
);

   logic signed [36:0] prod_ff;
   logic signed [36:0] prod_in;
   logic signed [20:0] step;
   logic signed [22:0] sum;
   logic signed [22:0] bound;
   logic signed [22:0] wrapped;

   assign prod_in = vel * $signed({1'b0, time_step});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Dropping the low sixteen bits of a two's complement value floors it.
   assign step  = prod_ff[36:16];
   assign sum   = $signed({3'b000, pos}) + $signed({{2{step[20]}}, step});
   assign bound = $signed({3'b000, bound_units, 8'h00});

   always_comb begin
      if (sum >= bound) begin
         wrapped = sum - bound;
      end else if (sum < 0) begin
         wrapped = sum + bound;
      end else begin
         wrapped = sum;
      end
   end

   assign next_pos = wrapped[19:0];

endmodule
